FILE: hdl/smbus_master_pec_sequencer_macros.svh
// ---------------------------------------------------------------------------
// SMBus master PEC sequencer assertion macros
// Shared concurrent assertion shorthands, clocked on clk, off during rst.
// ---------------------------------------------------------------------------
`ifndef SMBUS_MASTER_PEC_SEQUENCER_MACROS_SVH
`define SMBUS_MASTER_PEC_SEQUENCER_MACROS_SVH

// same-cycle implication
`define SMPEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMPEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/smpec_pkg.sv
// ---------------------------------------------------------------------------
// smpec_pkg
// Types, codes and the CRC-8 byte update of the SMBus master PEC sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package smpec_pkg;

  localparam int COUNT_W      = 8;
  localparam int TIMEOUT_W    = 14;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 14'd10000;
  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    FN_BEGIN_WR = 2'd0,
    FN_BEGIN_RD = 2'd1,
    FN_SUPPLY   = 2'd2,
    FN_TICK     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_START = 3'd1,
    EV_TXSEL = 3'd2,
    EV_RXSEL = 3'd3,
    EV_SENT  = 3'd4,
    EV_RECV  = 3'd5
  } event_t;

  typedef enum logic [3:0] {
    ACT_NONE    = 4'd0,
    ACT_START   = 4'd1,
    ACT_ADDR_WR = 4'd2,
    ACT_ADDR_RD = 4'd3,
    ACT_SEND    = 4'd4,
    ACT_STOP    = 4'd5,
    ACT_NEED    = 4'd6,
    ACT_READ    = 4'd7,
    ACT_OK      = 4'd8,
    ACT_TIMEOUT = 4'd9,
    ACT_PEC_ERR = 4'd10
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START1 = 4'd1,
    PH_ADDRW  = 4'd2,
    PH_REG    = 4'd3,
    PH_NEED   = 4'd4,
    PH_DATA   = 4'd5,
    PH_PEC    = 4'd6,
    PH_START2 = 4'd7,
    PH_ADDRR  = 4'd8,
    PH_RDATA  = 4'd9,
    PH_RPEC   = 4'd10
  } phase_t;

  typedef struct packed {
    action_t    act;
    logic [7:0] data;
    logic [6:0] addr;
    logic       last;
  } result_t;

  localparam result_t RESULT_NONE = '{act: ACT_NONE, data: 8'd0, addr: 7'd0, last: 1'b0};

  // CRC-8, polynomial x^8+x^2+x+1, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/smbus_master_pec_sequencer.sv
// ---------------------------------------------------------------------------
// smbus_master_pec_sequencer
// SMBus register write/read sequencer with CRC-8 packet error code.
// ---------------------------------------------------------------------------
// Each input word (begin, supply byte or bus tick) is captured in an input
// register and handled by the phase logic and the CRC-8 byte update, which
// pushes zero, one or two result words into a four-entry output queue. An
// item is taken every cycle as long as the queue holds two words or fewer;
// the queue drains one result word per cycle while out_ready is high, so the
// sustained rate is one item per cycle for items that give at most one
// result, and the queue read port sets the rate when results pile up. A
// result reaches the output through the input register and the output queue.
`default_nettype none

module smbus_master_pec_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [smpec_pkg::TIMEOUT_W-1:0] cfg_wr_data,
  // input words
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    func,
  input  wire logic [6:0]                    device_addr,
  input  wire logic [7:0]                    reg_addr,
  input  wire logic [7:0]                    byte_count,
  input  wire logic [7:0]                    data_byte,
  input  wire logic [2:0]                    bus_event,
  // result words
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [3:0]                         action,
  output logic [7:0]                         out_byte,
  output logic [6:0]                         out_addr,
  output logic                               last
);
  import smpec_pkg::*;

  // configuration
  logic [TIMEOUT_W-1:0] timeout_limit;

  // input register
  logic       stage_valid;
  func_t      s_func;
  logic [6:0] s_dev;
  logic [7:0] s_reg;
  logic [7:0] s_cnt;
  logic [7:0] s_data;
  logic [2:0] s_event;
  logic       stage_fire;

  // sequencer state
  phase_t               phase, phase_next;
  logic [7:0]           running_check, running_check_next;
  logic [COUNT_W-1:0]   bytes_left, bytes_left_next;
  logic [TIMEOUT_W-1:0] wait_count, wait_count_next;
  logic [6:0]           held_device, held_device_next;
  logic [7:0]           held_register, held_register_next;
  logic                 is_read, is_read_next;

  // output queue
  result_t          fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   fifo_count;
  logic             pop;

  event_t             want_ev;
  logic               timed, hit, expired;
  logic [COUNT_W-1:0] left_dec;
  result_t            res0, res1;
  logic [1:0]         n_res;

  assign stage_fire = stage_valid && (fifo_count <= (PTR_W+1)'(FIFO_DEPTH - 2));
  assign in_ready   = !stage_valid || stage_fire;
  assign pop        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_func  <= func_t'(func);
      s_dev   <= device_addr;
      s_reg   <= reg_addr;
      s_cnt   <= byte_count;
      s_data  <= data_byte;
      s_event <= bus_event;
    end
  end

  // awaited bus event for each phase
  always_comb begin
    case (phase)
      PH_START1, PH_START2:     want_ev = EV_START;
      PH_ADDRW:                 want_ev = EV_TXSEL;
      PH_ADDRR:                 want_ev = EV_RXSEL;
      PH_REG, PH_DATA, PH_PEC:  want_ev = EV_SENT;
      PH_RDATA, PH_RPEC:        want_ev = EV_RECV;
      default:                  want_ev = EV_NONE;
    endcase
  end

  assign timed    = (s_func == FN_TICK) && (want_ev != EV_NONE);
  assign hit      = timed && (s_event == want_ev);
  assign expired  = ({1'b0, wait_count} + (TIMEOUT_W+1)'(1)) >= {1'b0, timeout_limit};
  assign left_dec = bytes_left - COUNT_W'(1);

  // next state
  always_comb begin
    phase_next         = phase;
    running_check_next = running_check;
    bytes_left_next    = bytes_left;
    wait_count_next    = wait_count;
    held_device_next   = held_device;
    held_register_next = held_register;
    is_read_next       = is_read;
    case (s_func)
      FN_BEGIN_WR, FN_BEGIN_RD: begin
        if (phase == PH_IDLE) begin
          held_device_next   = s_dev;
          held_register_next = s_reg;
          bytes_left_next    = s_cnt[COUNT_W-1:0];
          is_read_next       = (s_func == FN_BEGIN_RD);
          running_check_next = 8'd0;
          wait_count_next    = '0;
          phase_next         = PH_START1;
        end
      end
      FN_SUPPLY: begin
        if (phase == PH_NEED) begin
          running_check_next = crc8_byte(running_check, s_data);
          bytes_left_next    = left_dec;
          wait_count_next    = '0;
          phase_next         = PH_DATA;
        end
      end
      default: begin
        if (timed && !hit) begin
          if (expired) begin
            wait_count_next = '0;
            phase_next      = PH_IDLE;
          end else begin
            wait_count_next = wait_count + TIMEOUT_W'(1);
          end
        end else if (hit) begin
          wait_count_next = '0;
          case (phase)
            PH_START1: phase_next = PH_ADDRW;
            PH_ADDRW:  phase_next = PH_REG;
            PH_REG: begin
              running_check_next = crc8_byte(8'd0, held_register);
              if (is_read) begin
                phase_next = PH_START2;
              end else begin
                phase_next = (bytes_left != '0) ? PH_NEED : PH_PEC;
              end
            end
            PH_DATA:   phase_next = (bytes_left != '0) ? PH_NEED : PH_PEC;
            PH_PEC:    phase_next = PH_IDLE;
            PH_START2: phase_next = PH_ADDRR;
            PH_ADDRR:  phase_next = (bytes_left != '0) ? PH_RDATA : PH_RPEC;
            PH_RDATA: begin
              running_check_next = crc8_byte(running_check, s_data);
              bytes_left_next    = left_dec;
              if (left_dec == '0) begin
                phase_next = PH_RPEC;
              end
            end
            PH_RPEC:   phase_next = PH_IDLE;
            default:   phase_next = phase;
          endcase
        end
      end
    endcase
  end

  // result words
  always_comb begin
    res0  = RESULT_NONE;
    res1  = RESULT_NONE;
    n_res = 2'd0;
    case (s_func)
      FN_BEGIN_WR, FN_BEGIN_RD: begin
        if (phase == PH_IDLE) begin
          res0.act = ACT_START;
          n_res    = 2'd1;
        end
      end
      FN_SUPPLY: begin
        if (phase == PH_NEED) begin
          res0.act  = ACT_SEND;
          res0.data = s_data;
          n_res     = 2'd1;
        end
      end
      default: begin
        if (timed && !hit) begin
          if (expired) begin
            res0.act = ACT_TIMEOUT;
            n_res    = 2'd1;
          end
        end else if (hit) begin
          n_res = 2'd1;
          case (phase)
            PH_START1: begin
              res0.act  = ACT_ADDR_WR;
              res0.addr = held_device;
            end
            PH_ADDRW: begin
              res0.act  = ACT_SEND;
              res0.data = held_register;
            end
            PH_REG, PH_DATA: begin
              if (phase == PH_REG && is_read) begin
                res0.act = ACT_START;
              end else if (bytes_left != '0) begin
                res0.act = ACT_NEED;
              end else begin
                // PEC goes out with the CRC as updated this cycle
                res0.act  = ACT_SEND;
                res0.data = running_check_next;
              end
            end
            PH_PEC: begin
              res0.act = ACT_STOP;
              res1.act = ACT_OK;
              n_res    = 2'd2;
            end
            PH_START2: begin
              res0.act  = ACT_ADDR_RD;
              res0.addr = held_device;
            end
            PH_ADDRR: n_res = 2'd0;
            PH_RDATA: begin
              res0.act  = ACT_READ;
              res0.data = s_data;
            end
            PH_RPEC: begin
              res0.act = ACT_STOP;
              res1.act = (s_data == running_check) ? ACT_OK : ACT_PEC_ERR;
              n_res    = 2'd2;
            end
            default: n_res = 2'd0;
          endcase
        end
      end
    endcase
    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      running_check <= 8'd0;
      bytes_left    <= '0;
      wait_count    <= '0;
      held_device   <= 7'd0;
      held_register <= 8'd0;
      is_read       <= 1'b0;
    end else if (stage_fire) begin
      phase         <= phase_next;
      running_check <= running_check_next;
      bytes_left    <= bytes_left_next;
      wait_count    <= wait_count_next;
      held_device   <= held_device_next;
      held_register <= held_register_next;
      is_read       <= is_read_next;
    end
  end

  // output queue: up to two pushes, one pop per cycle
  always_ff @(posedge clk) begin
    if (stage_fire && (n_res != 2'd0)) begin
      fifo_mem[wr_ptr] <= res0;
    end
    if (stage_fire && (n_res == 2'd2)) begin
      fifo_mem[wr_ptr + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + (stage_fire ? PTR_W'(n_res) : PTR_W'(0));
      rd_ptr     <= rd_ptr + (pop ? PTR_W'(1) : PTR_W'(0));
      fifo_count <= fifo_count + (stage_fire ? (PTR_W+1)'(n_res) : (PTR_W+1)'(0))
                    - (pop ? (PTR_W+1)'(1) : (PTR_W+1)'(0));
    end
  end

  assign out_valid = (fifo_count != '0);
  assign action    = fifo_mem[rd_ptr].act;
  assign out_byte  = fifo_mem[rd_ptr].data;
  assign out_addr  = fifo_mem[rd_ptr].addr;
  assign last      = fifo_mem[rd_ptr].last;

`include "smbus_master_pec_sequencer_macros.svh"

  `SMPEC_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_count <= (PTR_W+1)'(FIFO_DEPTH), "output queue overfilled")
  `SMPEC_ASSERT_NOW(a_pair_last, stage_fire && (n_res == 2'd2), !res0.last && res1.last, "last flag wrong on a result pair")
  `SMPEC_ASSERT_NEXT(a_push_visible, stage_fire && (n_res != 2'd0), out_valid, "pushed result not presented")
  `SMPEC_ASSERT_NOW(a_no_drop, stage_valid && !stage_fire, !in_ready, "input word taken while the stage is stalled")

endmodule

`default_nettype wire
